// File: design/gps_pkg.sv
// Shared types, constants and ROM tables for the gradient palette sampler.
// Used by every module of the block; depends on nothing.
package gps_pkg;

	localparam int NUM_PALETTES_DEF = 12;
	localparam int STOPS_DEF        = 5;
	localparam int GAMMA_X100_DEF   = 220;
	localparam int POS_FRAC_DEF     = 16;

	// widest position fraction the work queue is sized for
	localparam int POS_FRAC_MAX = 20;
	localparam int UW = POS_FRAC_MAX + 1;
	localparam int DW = POS_FRAC_MAX + 9;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int GAIN_W     = 12;
	localparam logic [GAIN_W-1:0] GAIN_UNITY = 12'd256;
	localparam logic [15:0] CH_MAX = 16'd65280;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAMMA_EN   = 3'd0,
		CFG_GAMMA_MODE = 3'd1,
		CFG_SAT_GAIN   = 3'd2,
		CFG_DITHER_EN  = 3'd3
	} gps_cfg_idx_t;

	typedef struct packed {
		logic              gamma_en;
		logic              gamma_mode;
		logic [GAIN_W-1:0] sat_gain;
		logic              dither_en;
	} gps_cfg_t;

	// one classified word between front and back
	typedef struct packed {
		logic                 ok;
		logic [3:0]           pid;
		logic [2:0]           lo;
		logic [2:0]           hi;
		logic [UW-1:0]        u;
		logic signed [DW-1:0] d;
		logic signed [8:0]    s;
		logic [2:0]           tb;
		logic [2:0]           cnt;
	} gps_item_t;

	typedef logic [15:0] gps_gam_lut_t [256];
	typedef logic [24:0] gps_rcp_lut_t [128];

	localparam logic [7:0] PAL_ROM [16][8][4] = '{
		'{'{0,205,148,82},'{28,225,170,110},'{55,242,192,140},'{82,254,210,170},
		  '{100,255,222,190},'{default:8'd0},'{default:8'd0},'{default:8'd0}},
		'{'{0,188,110,24},'{25,210,128,38},'{50,234,156,68},'{75,255,186,108},
		  '{100,255,204,140},'{default:8'd0},'{default:8'd0},'{default:8'd0}},
		'{'{0,150,70,34},'{25,176,90,56},'{55,206,122,90},'{78,228,150,116},
		  '{100,242,172,136},'{default:8'd0},'{default:8'd0},'{default:8'd0}},
		'{'{0,92,10,12},'{22,128,22,24},'{48,168,36,42},'{72,198,54,62},
		  '{100,225,74,80},'{default:8'd0},'{default:8'd0},'{default:8'd0}},
		'{'{0,12,72,52},'{22,22,110,88},'{50,44,150,132},'{78,70,185,170},
		  '{100,110,195,175},'{default:8'd0},'{default:8'd0},'{default:8'd0}},
		'{'{0,12,96,78},'{24,36,148,140},'{52,72,198,214},'{78,98,170,240},
		  '{100,72,130,236},'{default:8'd0},'{default:8'd0},'{default:8'd0}},
		'{'{0,10,58,140},'{30,26,96,182},'{55,60,150,224},'{78,90,196,255},
		  '{100,150,228,255},'{default:8'd0},'{default:8'd0},'{default:8'd0}},
		'{'{0,6,10,36},'{25,16,20,72},'{50,30,40,126},'{75,52,62,176},
		  '{100,82,102,206},'{default:8'd0},'{default:8'd0},'{default:8'd0}},
		'{'{0,182,196,220},'{24,200,214,236},'{52,220,234,250},'{78,238,246,255},
		  '{100,214,232,252},'{default:8'd0},'{default:8'd0},'{default:8'd0}},
		'{'{0,132,136,144},'{22,154,160,170},'{50,182,192,204},'{76,205,214,224},
		  '{100,186,198,214},'{default:8'd0},'{default:8'd0},'{default:8'd0}},
		'{'{0,198,208,224},'{26,214,224,238},'{54,234,244,252},'{80,246,252,255},
		  '{100,230,238,248},'{default:8'd0},'{default:8'd0},'{default:8'd0}},
		'{'{0,216,202,210},'{24,232,214,224},'{52,246,228,236},'{80,252,242,248},
		  '{100,232,218,228},'{default:8'd0},'{default:8'd0},'{default:8'd0}},
		'{default:'{default:8'd0}},
		'{default:'{default:8'd0}},
		'{default:'{default:8'd0}},
		'{default:'{default:8'd0}}
	};

	// shift-subtract divide, elaboration only
	function automatic longint unsigned gps_udiv(longint unsigned n, longint unsigned dv);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= dv) begin
				r = r - dv;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic longint unsigned gps_isqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// log2 in Q16 by repeated squaring
	function automatic longint unsigned gps_log2(longint unsigned v);
		longint unsigned msb;
		longint unsigned x;
		longint unsigned res;
		msb = 0;
		while (msb < 7 && (v >> (msb + 1)) != 0) msb = msb + 1;
		x = v << (30 - msb);
		res = msb << 16;
		for (int b = 15; b >= 0; b--) begin
			x = (x * x) >> 30;
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				res = res | (64'd1 << b);
			end
		end
		return res;
	endfunction

	// 2^(-n/65536) in Q30
	function automatic longint unsigned gps_exp2n(longint unsigned n);
		longint unsigned q;
		longint unsigned r;
		longint unsigned acc;
		longint unsigned c;
		q = n >> 16;
		r = n & 64'hFFFF;
		acc = 64'd1 << 30;
		c = 64'd1 << 29;
		for (int k = 1; k <= 16; k++) begin
			c = gps_isqrt(c << 30);
			if (((r >> (16 - k)) & 64'd1) != 0) acc = (acc * c) >> 30;
		end
		if (q >= 31) return 0;
		return acc >> q;
	endfunction

	function automatic gps_gam_lut_t gps_gam_lut(int g, bit mode);
		gps_gam_lut_t lut;
		longint unsigned li;
		longint unsigned lt;
		longint unsigned m;
		longint unsigned n;
		longint unsigned gv;
		lt = gps_log2(255);
		gv = longint'(g);
		lut[0] = 16'd0;
		for (int i = 1; i < 256; i++) begin
			li = gps_log2(longint'(i));
			m = (lt > li) ? lt - li : 0;
			n = mode ? gps_udiv(m * gv, 100) : gps_udiv(m * 100, gv);
			lut[i] = 16'((gps_exp2n(n) * 65280 + (64'd1 << 29)) >> 30);
		end
		return lut;
	endfunction

	// rounded 2^24 / span
	function automatic gps_rcp_lut_t gps_rcp_lut();
		gps_rcp_lut_t lut;
		longint unsigned sv;
		lut[0] = 25'd0;
		for (int i = 1; i < 128; i++) begin
			sv = longint'(i);
			lut[i] = 25'(gps_udiv((64'd1 << 24) + (sv >> 1), sv));
		end
		return lut;
	endfunction

endpackage

// File: design/gradient_palette_sampler_top.sv
// Gradient palette sampler: one color word per position word.
// Datapath: the queue, 3 stages, then the output register. Throughput: one word per cycle while
// the output slot is free or popped, set by the single-issue back pipeline.
// Reset clears config to defaults (saturation gain 256), the dither counter and all valids;
// no clearing pass, the block takes words right after reset.
module gradient_palette_sampler_top #(
	parameter int NUM_PALETTES      = gps_pkg::NUM_PALETTES_DEF,
	parameter int STOPS_PER_PALETTE = gps_pkg::STOPS_DEF,
	parameter int GAMMA_X100        = gps_pkg::GAMMA_X100_DEF,
	parameter int POS_FRAC_BITS     = gps_pkg::POS_FRAC_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [3:0]                      palette_id,
	input  logic signed [23:0]              position,
	input  logic [31:0]                     tick_ms,
	output logic                            empty,
	input  logic                            pop,
	output logic [7:0]                      red,
	output logic [7:0]                      green,
	output logic [7:0]                      blue,
	input  logic                            cfg_we,
	input  logic [gps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gps_pkg::CFG_DATA_W-1:0]  cfg_data
);

	gps_pkg::gps_cfg_t  cfg_q;
	gps_pkg::gps_item_t f_item;
	gps_pkg::gps_item_t q_item;
	logic f_wr;
	logic q_rd;
	logic q_empty;

	// hold config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gamma_en   <= 1'b0;
			cfg_q.gamma_mode <= 1'b0;
			cfg_q.sat_gain   <= gps_pkg::GAIN_UNITY;
			cfg_q.dither_en  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gps_pkg::CFG_GAMMA_EN:   cfg_q.gamma_en   <= cfg_data[0];
				gps_pkg::CFG_GAMMA_MODE: cfg_q.gamma_mode <= cfg_data[0];
				gps_pkg::CFG_SAT_GAIN:   cfg_q.sat_gain   <= cfg_data[gps_pkg::GAIN_W-1:0];
				gps_pkg::CFG_DITHER_EN:  cfg_q.dither_en  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	gps_front #(
		.NUM_PALETTES(NUM_PALETTES),
		.STOPS_PER_PALETTE(STOPS_PER_PALETTE),
		.POS_FRAC_BITS(POS_FRAC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.q_full(full),
		.palette_id(palette_id),
		.position(position),
		.tick_ms(tick_ms),
		.item_wr(f_wr),
		.item(f_item)
	);

	gps_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(f_wr),
		.wdata(f_item),
		.rd(q_rd),
		.rdata(q_item),
		.full(full),
		.empty(q_empty)
	);

	gps_back #(
		.GAMMA_X100(GAMMA_X100),
		.POS_FRAC_BITS(POS_FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item(q_item),
		.q_empty(q_empty),
		.q_rd(q_rd),
		.pop(pop),
		.empty(empty),
		.red(red),
		.green(green),
		.blue(blue)
	);

endmodule

// File: design/gps_queue.sv
// Two-word queue between the classifying front and the color back end.
// Depends on gps_pkg for the word type.
module gps_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  gps_pkg::gps_item_t   wdata,
	input  logic                 rd,
	output gps_pkg::gps_item_t   rdata,
	output logic                 full,
	output logic                 empty
);

	gps_pkg::gps_item_t mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	// store word
	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= ~wp_q;
			if (rd && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr && !full) - 2'(rd && !empty);
		end
	end

endmodule

// File: design/gps_front.sv
// Front end: wraps the position, validates the palette, finds the bounding stops.
// Depends on gps_pkg for the palette ROM and word type.
module gps_front #(
	parameter int NUM_PALETTES      = gps_pkg::NUM_PALETTES_DEF,
	parameter int STOPS_PER_PALETTE = gps_pkg::STOPS_DEF,
	parameter int POS_FRAC_BITS     = gps_pkg::POS_FRAC_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               q_full,
	input  logic [3:0]         palette_id,
	input  logic signed [23:0] position,
	input  logic [31:0]        tick_ms,
	output logic               item_wr,
	output gps_pkg::gps_item_t item
);

	localparam int PF = POS_FRAC_BITS;
	localparam logic [22:0] ONE = 23'(1 << PF);

	logic [2:0]         cnt_q;
	logic               ok;
	logic               found;
	logic [PF:0]        u;
	logic [PF+7:0]      u100;
	logic [PF+7:0]      hpos;
	logic [2:0]         lo;
	logic [2:0]         hi;
	logic [7:0]         hlo;
	logic [7:0]         hhi;
	logic signed [PF+8:0] d;

	assign item_wr = push && !q_full;

	// classify the word
	always_comb begin
		ok = ({1'b0, palette_id} < 5'(NUM_PALETTES));
		if (position[23] || (position[22:0] > ONE)) u = {1'b0, position[PF-1:0]};
		else u = position[PF:0];
		u100 = (PF+8)'(u) * (PF+8)'(100);
		lo = 3'd0;
		hi = 3'(STOPS_PER_PALETTE - 1);
		found = 1'b0;
		hpos = '0;
		for (int i = 1; i < STOPS_PER_PALETTE; i++) begin
			hpos = (PF+8)'(gps_pkg::PAL_ROM[palette_id][i][0]) << PF;
			if (!found && (u100 <= hpos)) begin
				lo = 3'(i - 1);
				hi = 3'(i);
				found = 1'b1;
			end
		end
		hlo = gps_pkg::PAL_ROM[palette_id][lo][0];
		hhi = gps_pkg::PAL_ROM[palette_id][hi][0];
		d = $signed({1'b0, u100}) - $signed({1'b0, (PF+8)'(hlo) << PF});
		item.ok  = ok;
		item.pid = palette_id;
		item.lo  = lo;
		item.hi  = hi;
		item.u   = gps_pkg::UW'(u);
		item.d   = gps_pkg::DW'(d);
		item.s   = $signed({1'b0, hhi}) - $signed({1'b0, hlo});
		item.tb  = tick_ms[3:1];
		item.cnt = cnt_q;
	end

	// advance the dither counter on each valid palette
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (item_wr && ok) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

endmodule

// File: design/gps_back.sv
// Back end: interpolation, gamma, saturation lift, rounding and dither.
// Depends on gps_pkg for the ROM tables, config and word types.
module gps_back #(
	parameter int GAMMA_X100    = gps_pkg::GAMMA_X100_DEF,
	parameter int POS_FRAC_BITS = gps_pkg::POS_FRAC_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gps_pkg::gps_cfg_t  cfg,
	input  gps_pkg::gps_item_t item,
	input  logic               q_empty,
	output logic               q_rd,
	input  logic               pop,
	output logic               empty,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);

	localparam int PF = POS_FRAC_BITS;
	localparam int GEFF = (GAMMA_X100 < 10) ? 10 : GAMMA_X100;
	localparam gps_pkg::gps_gam_lut_t GLUT0 = gps_pkg::gps_gam_lut(GEFF, 1'b0);
	localparam gps_pkg::gps_gam_lut_t GLUT1 = gps_pkg::gps_gam_lut(GEFF, 1'b1);
	localparam gps_pkg::gps_rcp_lut_t RCP   = gps_pkg::gps_rcp_lut();

	logic adv;
	logic out_v_q;
	logic v_s1, v_s2, v_s3;
	logic ok_s1, ok_s2, ok_s3;
	logic [2:0] seed_s1, seed_s2, seed_s3;
	logic [16:0] t_s1;
	logic [7:0]  c0_s1 [3];
	logic [7:0]  c1_s1 [3];
	logic [15:0] rgb_s2 [3];
	logic [15:0] rgb_s3 [3];
	logic [15:0] luma_s3;
	logic [7:0]  red_q, green_q, blue_q;

	logic [PF+32:0] prod;
	logic [24:0]    tt;
	logic [16:0]    t_n;
	logic [PF+14:0] hash;
	logic [24:0]    mix [3];
	logic [15:0]    lin [3];
	logic [16:0]    gidx [3];
	logic [15:0]    gam_n [3];
	logic [32:0]    lsum;
	logic [7:0]     fin [3];
	logic signed [17:0] diff;
	logic signed [30:0] p;
	logic [30:0]    pm;
	logic [30:0]    qm;
	logic signed [31:0] csat;
	logic [15:0]    cc;
	logic [16:0]    rnd;
	logic           sat_on;

	// whole pipe moves when the output slot frees
	assign adv   = !out_v_q || pop;
	assign q_rd  = adv && !q_empty;
	assign empty = !out_v_q;
	assign red   = red_q;
	assign green = green_q;
	assign blue  = blue_q;

	// stage 1: blend weight, dither seed, stop colors
	always_comb begin
		prod = (PF+33)'(item.d[PF+7:0]) * (PF+33)'(RCP[item.s[6:0]]);
		tt   = 25'(prod >> (PF + 8));
		if (item.s > 0 && item.d > 0) t_n = (tt > 25'd65536) ? 17'd65536 : tt[16:0];
		else t_n = 17'd0;
		hash = (PF+15)'(item.u[PF:0]) * (PF+15)'(10000);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1   <= item.ok;
			t_s1    <= t_n;
			seed_s1 <= hash[PF+2:PF] ^ item.tb ^ item.cnt;
			for (int k = 0; k < 3; k++) begin
				c0_s1[k] <= gps_pkg::PAL_ROM[item.pid][item.lo][k+1];
				c1_s1[k] <= gps_pkg::PAL_ROM[item.pid][item.hi][k+1];
			end
		end
	end

	// stage 2: interpolate in Q8.8 and apply gamma
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mix[k] = 25'(c0_s1[k]) * 25'(17'd65536 - t_s1) + 25'(c1_s1[k]) * 25'(t_s1)
			       + 25'd128;
			lin[k] = mix[k][23:8];
			gidx[k] = 17'(lin[k]) + 17'd128;
			gam_n[k] = cfg.gamma_mode ? GLUT1[gidx[k][15:8]] : GLUT0[gidx[k][15:8]];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s2   <= ok_s1;
			seed_s2 <= seed_s1;
			for (int k = 0; k < 3; k++) rgb_s2[k] <= cfg.gamma_en ? gam_n[k] : lin[k];
		end
	end

	// stage 3: Rec.709 luma
	always_comb begin
		lsum = 33'(rgb_s2[0]) * 33'd13933 + 33'(rgb_s2[1]) * 33'd46871
		     + 33'(rgb_s2[2]) * 33'd4732 + 33'd32768;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s3   <= ok_s2;
			seed_s3 <= seed_s2;
			luma_s3 <= lsum[31:16];
			for (int k = 0; k < 3; k++) rgb_s3[k] <= rgb_s2[k];
		end
	end

	// stage 4: saturation lift, clamp, round, dither
	always_comb begin
		sat_on = (cfg.sat_gain != '0) && (cfg.sat_gain != gps_pkg::GAIN_UNITY);
		diff = '0;
		p = '0;
		pm = '0;
		qm = '0;
		csat = '0;
		cc = '0;
		rnd = '0;
		for (int k = 0; k < 3; k++) begin
			diff = $signed({2'b00, rgb_s3[k]}) - $signed({2'b00, luma_s3});
			p    = 31'(diff) * $signed({19'd0, cfg.sat_gain});
			pm   = p[30] ? 31'(-p) : 31'(p);
			qm   = (pm + 31'd128) >> 8;
			csat = $signed({16'd0, luma_s3}) + (p[30] ? -$signed({1'b0, qm}) : $signed({1'b0, qm}));
			if (!sat_on) cc = rgb_s3[k];
			else if (csat < 0) cc = 16'd0;
			else if (csat > $signed({16'd0, gps_pkg::CH_MAX})) cc = gps_pkg::CH_MAX;
			else cc = csat[15:0];
			if (cc > gps_pkg::CH_MAX) cc = gps_pkg::CH_MAX;
			rnd = 17'(cc) + 17'd128;
			fin[k] = rnd[15:8];
			if (cfg.dither_en && fin[k] != 8'd0 && fin[k] != 8'd255 && seed_s3[k])
				fin[k] = fin[k] + 8'd1;
			if (!ok_s3) fin[k] = 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			red_q   <= fin[0];
			green_q <= fin[1];
			blue_q  <= fin[2];
		end
	end

	// advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= !q_empty;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			out_v_q <= v_s3;
		end
	end

endmodule

// File: tb/sv/gradient_palette_sampler_top_tb.sv
// Self-checking testbench for gradient_palette_sampler_top: queue-style driver and monitor.
// Depends on gps_pkg for the config register indexes; predicts colors with its own model.
module gradient_palette_sampler_top_tb;

	typedef struct {
		logic [3:0]         pid;
		logic signed [23:0] pos;
		logic [31:0]        tick;
	} sample_t;

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} color_t;

	// palette stops: position in hundredths, then R, G, B
	localparam int STOP_TAB [12][5][4] = '{
		'{'{0,205,148,82},'{28,225,170,110},'{55,242,192,140},'{82,254,210,170},'{100,255,222,190}},
		'{'{0,188,110,24},'{25,210,128,38},'{50,234,156,68},'{75,255,186,108},'{100,255,204,140}},
		'{'{0,150,70,34},'{25,176,90,56},'{55,206,122,90},'{78,228,150,116},'{100,242,172,136}},
		'{'{0,92,10,12},'{22,128,22,24},'{48,168,36,42},'{72,198,54,62},'{100,225,74,80}},
		'{'{0,12,72,52},'{22,22,110,88},'{50,44,150,132},'{78,70,185,170},'{100,110,195,175}},
		'{'{0,12,96,78},'{24,36,148,140},'{52,72,198,214},'{78,98,170,240},'{100,72,130,236}},
		'{'{0,10,58,140},'{30,26,96,182},'{55,60,150,224},'{78,90,196,255},'{100,150,228,255}},
		'{'{0,6,10,36},'{25,16,20,72},'{50,30,40,126},'{75,52,62,176},'{100,82,102,206}},
		'{'{0,182,196,220},'{24,200,214,236},'{52,220,234,250},'{78,238,246,255},'{100,214,232,252}},
		'{'{0,132,136,144},'{22,154,160,170},'{50,182,192,204},'{76,205,214,224},'{100,186,198,214}},
		'{'{0,198,208,224},'{26,214,224,238},'{54,234,244,252},'{80,246,252,255},'{100,230,238,248}},
		'{'{0,216,202,210},'{24,232,214,224},'{52,246,228,236},'{80,252,242,248},'{100,232,218,228}}
	};
	localparam longint ONE = 64'd1 << 16;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic [3:0] palette_id = 0;
	logic signed [23:0] position = 0;
	logic [31:0] tick_ms = 0;
	logic empty;
	logic pop = 0;
	logic [7:0] red, green, blue;
	logic cfg_we = 0;
	logic [gps_pkg::CFG_IDX_W-1:0] cfg_index = 0;
	logic [gps_pkg::CFG_DATA_W-1:0] cfg_data = 0;

	gradient_palette_sampler_top u_dut (.*);

	// predictor state
	bit gam_en, gam_mode, dith_en;
	bit [11:0] sat_gain = 256;
	bit [2:0] dith_count;

	sample_t pending_samples[$];
	color_t expected_colors[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit send_hold = 0;
	bit recv_hold = 0;

	initial forever #6 clk = ~clk;

	// log2 in Q16 by repeated squaring
	function automatic longint unsigned log2_q16(longint unsigned v);
		longint unsigned msb, x, res;
		msb = 0;
		while (msb < 7 && (v >> (msb + 1)) != 0) msb++;
		x = v << (30 - msb);
		res = msb << 16;
		for (int b = 15; b >= 0; b--) begin
			x = (x * x) >> 30;
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				res |= 64'd1 << b;
			end
		end
		return res;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned pow2_neg(longint unsigned n);
		longint unsigned acc, c;
		acc = 64'd1 << 30;
		c = 64'd1 << 29;
		for (int k = 1; k <= 16; k++) begin
			c = int_sqrt(c << 30);
			if ((n >> (16 - k)) & 1) acc = (acc * c) >> 30;
		end
		if ((n >> 16) >= 31) return 0;
		return acc >> (n >> 16);
	endfunction

	function automatic longint unsigned gamma_curve(longint unsigned c);
		longint unsigned idx, li, lt, m, n;
		idx = (c + 128) >> 8;
		if (idx > 255) idx = 255;
		if (idx == 0) return 0;
		li = log2_q16(idx);
		lt = log2_q16(255);
		m = lt > li ? lt - li : 0;
		n = gam_mode ? (m * 220) / 100 : (m * 100) / 220;
		return (pow2_neg(n) * 65280 + (64'd1 << 29)) >> 30;
	endfunction

	// compute the color for one sample and, for a valid palette, advance the dither counter
	function automatic color_t sample_color(sample_t s);
		color_t o;
		longint pos, u, d, span, luma, p, q, c;
		longint unsigned t, recip, tt, seed;
		longint unsigned rgb [3];
		int lo, hi, pid;
		o = '{0, 0, 0};
		if (s.pid >= 12) return o;
		pid = s.pid;
		pos = s.pos;
		u = (pos < 0 || pos > ONE) ? (pos & (ONE - 1)) : pos;
		lo = 0;
		hi = 4;
		for (int i = 1; i < 5; i++) begin
			if (u * 100 <= STOP_TAB[pid][i][0] * ONE) begin
				lo = i - 1;
				hi = i;
				break;
			end
		end
		d = u * 100 - STOP_TAB[pid][lo][0] * ONE;
		span = STOP_TAB[pid][hi][0] - STOP_TAB[pid][lo][0];
		t = 0;
		if (span > 0 && d > 0) begin
			recip = ((64'd1 << 24) + span / 2) / span;
			tt = (longint'(d) * recip) >> 24;
			t = tt > 65536 ? 65536 : tt;
		end
		for (int k = 0; k < 3; k++) begin
			rgb[k] = (STOP_TAB[pid][lo][k+1] * (65536 - t) + STOP_TAB[pid][hi][k+1] * t + 128) >> 8;
			if (gam_en) rgb[k] = gamma_curve(rgb[k]);
		end
		if (sat_gain != 0 && sat_gain != 256) begin
			luma = (13933 * rgb[0] + 46871 * rgb[1] + 4732 * rgb[2] + 32768) >> 16;
			for (int k = 0; k < 3; k++) begin
				p = (longint'(rgb[k]) - luma) * longint'(sat_gain);
				q = p >= 0 ? (p + 128) >>> 8 : -((-p + 128) >>> 8);
				c = luma + q;
				if (c < 0) c = 0;
				if (c > 65280) c = 65280;
				rgb[k] = c;
			end
		end
		for (int k = 0; k < 3; k++) begin
			if (rgb[k] > 65280) rgb[k] = 65280;
			rgb[k] = (rgb[k] + 128) >> 8;
		end
		if (dith_en) begin
			seed = (((u * 10000) >> 16) ^ (s.tick >> 1) ^ ((dith_count * 64'd2654435761)
				& 64'hFFFF_FFFF)) & 64'hFFFF_FFFF;
			for (int k = 0; k < 3; k++)
				if (rgb[k] > 0 && rgb[k] < 255 && ((seed >> k) & 1)) rgb[k]++;
		end
		dith_count++;
		o.r = 8'(rgb[0]);
		o.g = 8'(rgb[1]);
		o.b = 8'(rgb[2]);
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// drive words from the pending queue, predicting each accepted one
	always @(posedge clk) begin
		sample_t s;
		if (arst_n) begin
			if (push && !full) begin
				s = pending_samples.pop_front();
				expected_colors.push_back(sample_color(s));
			end
			if ((!push || !full) && pending_samples.size() > 0 && !send_hold
					&& $urandom_range(99) >= send_idle_pct) begin
				s = pending_samples[0];
				push <= 1;
				palette_id <= s.pid;
				position <= s.pos;
				tick_ms <= s.tick;
			end else if (!push || !full) begin
				push <= 0;
			end
		end
	end

	// check each popped word and choose the next pop
	always @(posedge clk) begin
		color_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_colors.size() == 0) begin
					report_mismatch("unexpected word", 1, 0);
				end else begin
					e = expected_colors.pop_front();
					if (red !== e.r) report_mismatch("red", red, e.r);
					if (green !== e.g) report_mismatch("green", green, e.g);
					if (blue !== e.b) report_mismatch("blue", blue, e.b);
				end
			end
			pop <= !recv_hold && $urandom_range(99) >= recv_stall_pct;
		end
	end

	task automatic queue_sample(int pid, int pos, int unsigned tick);
		sample_t s;
		s.pid = 4'(pid);
		s.pos = 24'(pos);
		s.tick = tick;
		pending_samples.push_back(s);
	endtask

	task automatic queue_random(int n);
		int unsigned r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(9);
			if (r < 6) queue_sample($urandom_range(11), $urandom_range(65536), $urandom);
			else if (r < 8) queue_sample($urandom_range(11), $urandom, $urandom);
			else queue_sample($urandom_range(15), $urandom, $urandom);
		end
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || push || expected_colors.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(gps_pkg::gps_cfg_idx_t idx, int value);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= gps_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 0;
		// mirror the write in the predictor
		case (idx)
			gps_pkg::CFG_GAMMA_EN: gam_en = value[0];
			gps_pkg::CFG_GAMMA_MODE: gam_mode = value[0];
			gps_pkg::CFG_SAT_GAIN: sat_gain = 12'(value);
			gps_pkg::CFG_DITHER_EN: dith_en = value[0];
			default: ;
		endcase
	endtask

	task automatic set_regs(int ge, int gm, int sg, int de);
		write_reg(gps_pkg::CFG_GAMMA_EN, ge);
		write_reg(gps_pkg::CFG_GAMMA_MODE, gm);
		write_reg(gps_pkg::CFG_SAT_GAIN, sg);
		write_reg(gps_pkg::CFG_DITHER_EN, de);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		// directed: field extremes, stop boundaries, wrap, invalid palettes
		queue_sample(0, 0, 0);
		queue_sample(11, 65536, 32'hFFFF_FFFF);
		queue_sample(3, -8388608, 32'hAAAA_AAAA);
		queue_sample(5, 8388607, 32'h5555_5555);
		queue_sample(12, 1000, 7);
		queue_sample(15, -1, 32'hFFFF_FFFF);
		queue_sample(1, 16384, 1);
		queue_sample(2, 65537, 2);
		queue_sample(6, -65536, 3);
		queue_sample(7, 32768, 6);
		queue_sample(9, 1, 0);
		drain();
		set_regs(1, 0, 0, 1);
		for (int p = 0; p < 16; p++) queue_sample(p, p * 4200, p * 3);
		drain();
		// random phases across idling mixes and register settings
		for (int ph = 0; ph < 8; ph++) begin
			send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 54 : 0;
			recv_stall_pct = (ph % 4 == 2) ? 54 : (ph % 4 == 3) ? 36 : 0;
			if (ph % 4 == 3) send_idle_pct = 36;
			case (ph)
				0: set_regs(0, 0, 256, 0);
				1: set_regs(1, 1, 4095, 1);
				2: set_regs(1, 0, 128, 0);
				3: set_regs(0, 1, 512, 1);
				4: set_regs(1, 1, 0, 0);
				5: set_regs(0, 0, $urandom_range(4095), 1);
				6: set_regs(1, 0, 1, 1);
				default: set_regs($urandom_range(1), $urandom_range(1), $urandom_range(4095), 1);
			endcase
			if (ph == 2) begin
				// hold off the receiver so the block fills and backs up
				recv_hold = 1;
				queue_random(60);
				repeat (200) @(posedge clk);
				recv_hold = 0;
				drain();
			end
			queue_random(55);
			drain();
		end
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("simulation failed");
		$finish;
	end

endmodule
